>>> src/assert_macros.svh
// Assertion shorthands for the route table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rlt_pkg.sv
package rlt_pkg;

    localparam int ENTRIES = 64;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int LEN_W   = 6;

    localparam int FLAG_DEST = 0;
    localparam int FLAG_MASK = 1;
    localparam int FLAG_IMAC = 2;
    localparam int FLAG_GMAC = 3;
    localparam int FLAG_IIP  = 4;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ROUTE   = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    // One stored route, prefix length precomputed on add.
    typedef struct packed {
        logic [31:0]      dest;
        logic [31:0]      mask;
        logic [4:0]       flags;
        logic [LEN_W-1:0] len;
        logic [7:0]       distance;
        logic [31:0]      cost;
        logic [47:0]      imac;
        logic [47:0]      gmac;
        logic [31:0]      iip;
    } t_route;

    // Query and best match so far, passed from cell to cell.
    typedef struct packed {
        logic [31:0]      addr;
        logic             found;
        logic [LEN_W-1:0] len;
        logic [7:0]       distance;
        logic [31:0]      cost;
        logic             complete;
        logic [47:0]      imac;
        logic [47:0]      gmac;
        logic [31:0]      iip;
    } t_scan;

    function automatic logic [LEN_W-1:0] popcount32(input logic [31:0] v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int k = 0; k < 16; k++) begin
            s1[k] = {1'b0, v[2*k]} + {1'b0, v[2*k+1]};
        end
        for (int k = 0; k < 8; k++) begin
            s2[k] = {1'b0, s1[2*k]} + {1'b0, s1[2*k+1]};
        end
        for (int k = 0; k < 4; k++) begin
            s3[k] = {1'b0, s2[2*k]} + {1'b0, s2[2*k+1]};
        end
        for (int k = 0; k < 2; k++) begin
            s4[k] = {1'b0, s3[2*k]} + {1'b0, s3[2*k+1]};
        end
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

endpackage

>>> src/rlt_cell.sv
module rlt_cell
    import rlt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_active,
    input  logic   i_wr_en,
    input  t_route i_wr,
    input  logic   i_valid,
    input  t_scan  i_scan,
    output logic   o_valid,
    output t_scan  o_scan
);

    t_route      r_entry;
    logic        r_valid;
    t_scan       r_scan;
    t_scan       n_scan;
    logic [31:0] w_eff;
    logic        w_hit;
    logic        w_better;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr;
        end
    end

    always_comb begin
        w_eff = r_entry.flags[FLAG_MASK] ? (i_scan.addr & r_entry.mask) : i_scan.addr;
        w_hit = i_active && r_entry.flags[FLAG_DEST] && (w_eff == r_entry.dest);
        // strictly better only, so ties keep the lower index upstream
        w_better = !i_scan.found || (r_entry.len > i_scan.len) ||
                   ((r_entry.len == i_scan.len) &&
                    ((r_entry.distance < i_scan.distance) ||
                     ((r_entry.distance == i_scan.distance) &&
                      (r_entry.cost < i_scan.cost))));
        n_scan = i_scan;
        if (w_hit && w_better) begin
            n_scan.found    = 1'b1;
            n_scan.len      = r_entry.len;
            n_scan.distance = r_entry.distance;
            n_scan.cost     = r_entry.cost;
            n_scan.complete = r_entry.flags[FLAG_IMAC] && r_entry.flags[FLAG_GMAC] &&
                              r_entry.flags[FLAG_IIP];
            n_scan.imac     = r_entry.imac;
            n_scan.gmac     = r_entry.gmac;
            n_scan.iip      = r_entry.iip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_scan <= n_scan;
        end
    end

    assign o_valid = r_valid;
    assign o_scan  = r_scan;

endmodule

>>> src/ipv4_route_lookup_table.sv
// Route table with longest-prefix-match lookup. Each of the ENTRIES routes lives in its own
// cell of a chain; a lookup walks the chain one cell per cycle, each cell folding its route
// into the best match so far (longest prefix, then lowest distance, cost and index). A lookup
// occupies the block until its result leaves the cell chain; add, clear and the unused op
// code hold it until their status moves to the output. One item is in work at a time; the
// next item is accepted while the previous result still waits in the output register. An
// add to a full table is dropped and answered with the table-full status.
`include "assert_macros.svh"

module ipv4_route_lookup_table
    import rlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_dest_addr,
    input  logic [31:0] i_dest_mask,
    input  logic [4:0]  i_present_flags,
    input  logic [7:0]  i_route_distance,
    input  logic [31:0] i_route_cost,
    input  logic [47:0] i_iface_mac,
    input  logic [47:0] i_gateway_mac,
    input  logic [31:0] i_iface_ip,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [47:0] o_src_mac,
    output logic [47:0] o_dst_mac,
    output logic [31:0] o_src_ip
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_pend_valid;
    logic             n_pend_valid;
    t_status          r_pend_status;
    t_status          n_pend_status;
    logic             r_out_valid;
    t_status          r_out_status;
    logic [47:0]      r_out_src_mac;
    logic [47:0]      r_out_dst_mac;
    logic [31:0]      r_out_src_ip;

    logic             w_in_fire;
    logic             w_busy;
    logic             w_full;
    logic             w_add_en;
    logic             w_lookup;
    logic             w_out_free;
    logic             w_adv;
    t_route           w_wr;
    logic [ENTRIES:0] w_chain_valid;
    t_scan            w_chain [ENTRIES+1];
    t_scan            w_tail;

    assign w_busy     = (|w_chain_valid[ENTRIES:1]) || r_pend_valid;
    assign o_in_ready = !w_busy;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(ENTRIES));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_tail     = w_chain[ENTRIES];
    // hold the chain only while its result cannot leave
    assign w_adv      = w_out_free || !w_chain_valid[ENTRIES];

    always_comb begin
        w_wr.dest     = i_dest_addr;
        w_wr.mask     = i_dest_mask;
        w_wr.flags    = i_present_flags;
        w_wr.len      = i_present_flags[FLAG_MASK] ? popcount32(i_dest_mask) : LEN_W'(32);
        w_wr.distance = i_route_distance;
        w_wr.cost     = i_route_cost;
        w_wr.imac     = i_iface_mac;
        w_wr.gmac     = i_gateway_mac;
        w_wr.iip      = i_iface_ip;
    end

    always_comb begin
        n_count       = r_count;
        n_pend_valid  = r_pend_valid;
        n_pend_status = r_pend_status;
        w_add_en      = 1'b0;
        w_lookup      = 1'b0;
        if (r_pend_valid && w_out_free) begin
            n_pend_valid = 1'b0;
        end
        if (w_in_fire) begin
            unique case (t_op'(i_op))
                OP_ADD: begin
                    n_pend_valid = 1'b1;
                    if (w_full) begin
                        n_pend_status = ST_FULL;
                    end else begin
                        n_pend_status = ST_OK;
                        w_add_en      = 1'b1;
                        n_count       = r_count + CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    n_pend_valid  = 1'b1;
                    n_pend_status = ST_OK;
                    n_count       = '0;
                end
                OP_LOOKUP: begin
                    w_lookup = 1'b1;
                end
                OP_NOP: begin
                    n_pend_valid  = 1'b1;
                    n_pend_status = ST_OK;
                end
                default: begin
                    n_pend_valid = n_pend_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
    end

    assign w_chain_valid[0] = w_lookup;
    assign w_chain[0]       = '{addr: i_dest_addr, default: '0};

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        rlt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_active (r_count > CNT_W'(k)),
            .i_wr_en  (w_add_en && (r_count == CNT_W'(k))),
            .i_wr     (w_wr),
            .i_valid  (w_chain_valid[k]),
            .i_scan   (w_chain[k]),
            .o_valid  (w_chain_valid[k+1]),
            .o_scan   (w_chain[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_pend_valid || w_chain_valid[ENTRIES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_pend_valid) begin
                r_out_status  <= r_pend_status;
                r_out_src_mac <= '0;
                r_out_dst_mac <= '0;
                r_out_src_ip  <= '0;
            end else if (!w_tail.found) begin
                r_out_status  <= ST_NO_ROUTE;
                r_out_src_mac <= '0;
                r_out_dst_mac <= '0;
                r_out_src_ip  <= '0;
            end else if (!w_tail.complete) begin
                r_out_status  <= ST_INCOMPLETE;
                r_out_src_mac <= '0;
                r_out_dst_mac <= '0;
                r_out_src_ip  <= '0;
            end else begin
                r_out_status  <= ST_OK;
                r_out_src_mac <= w_tail.imac;
                r_out_dst_mac <= w_tail.gmac;
                r_out_src_ip  <= w_tail.iip;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_src_mac   = r_out_src_mac;
    assign o_dst_mac   = r_out_dst_mac;
    assign o_src_ip    = r_out_src_ip;

    `ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(ENTRIES), "route count beyond table size")
    `ASSERT_ALWAYS(a_one_in_work, $onehot0({w_chain_valid[ENTRIES:1], r_pend_valid}),
                   "more than one item in work")
    `ASSERT_NEXT(a_lookup_enters, w_lookup, w_chain_valid[1], "lookup did not enter the chain")
    `ASSERT_NEXT(a_full_drop, w_in_fire && (i_op == OP_ADD) && w_full,
                 (r_count == $past(r_count)) && (r_pend_status == ST_FULL),
                 "add to full table not dropped")

endmodule

>>> tb/route_lookup_checker.sv
module route_lookup_checker
    import rlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_dest_addr,
    input  logic [31:0] i_dest_mask,
    input  logic [4:0]  i_present_flags,
    input  logic [7:0]  i_route_distance,
    input  logic [31:0] i_route_cost,
    input  logic [47:0] i_iface_mac,
    input  logic [47:0] i_gateway_mac,
    input  logic [31:0] i_iface_ip,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [47:0] i_src_mac,
    input  logic [47:0] i_dst_mac,
    input  logic [31:0] i_src_ip,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_status     status;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
    } t_route_reply;

    // Mirror of the route table
    logic [31:0] rt_dest  [ENTRIES];
    logic [31:0] rt_mask  [ENTRIES];
    logic [4:0]  rt_flags [ENTRIES];
    logic [7:0]  rt_dist  [ENTRIES];
    logic [31:0] rt_cost  [ENTRIES];
    logic [47:0] rt_imac  [ENTRIES];
    logic [47:0] rt_gmac  [ENTRIES];
    logic [31:0] rt_iip   [ENTRIES];
    int          route_count = 0;
    int          fails = 0;

    t_route_reply pending_replies[$];

    function automatic t_route_reply resolve_lookup(input logic [31:0] addr);
        t_route_reply reply;
        logic         found;
        logic         hit;
        int           best;
        int           best_len;
        int           plen;
        reply    = '0;
        found    = 1'b0;
        best     = 0;
        best_len = 0;
        for (int i = 0; i < route_count; i++) begin
            if (rt_flags[i][FLAG_MASK]) begin
                hit  = ((addr & rt_mask[i]) == rt_dest[i]);
                plen = $countones(rt_mask[i]);
            end else begin
                hit  = (addr == rt_dest[i]);
                plen = 32;
            end
            // longest prefix, then lowest distance, then lowest cost; earlier index keeps ties
            if (rt_flags[i][FLAG_DEST] && hit) begin
                if (!found || plen > best_len ||
                    (plen == best_len &&
                     (rt_dist[i] < rt_dist[best] ||
                      (rt_dist[i] == rt_dist[best] && rt_cost[i] < rt_cost[best])))) begin
                    found    = 1'b1;
                    best     = i;
                    best_len = plen;
                end
            end
        end
        if (!found) begin
            reply.status = ST_NO_ROUTE;
        end else if (!(rt_flags[best][FLAG_IMAC] && rt_flags[best][FLAG_GMAC] &&
                       rt_flags[best][FLAG_IIP])) begin
            reply.status = ST_INCOMPLETE;
        end else begin
            reply.status  = ST_OK;
            reply.src_mac = rt_imac[best];
            reply.dst_mac = rt_gmac[best];
            reply.src_ip  = rt_iip[best];
        end
        return reply;
    endfunction

    always @(posedge i_clk) begin : watch
        t_route_reply want;
        t_route_reply got;
        if (!i_rst_n) begin
            pending_replies.delete();
            route_count = 0;
        end else begin
            // compare before predicting: a result never belongs to the item taken this edge
            if (i_out_valid && i_out_ready) begin
                got.status  = t_status'(i_status);
                got.src_mac = i_src_mac;
                got.dst_mac = i_dst_mac;
                got.src_ip  = i_src_ip;
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected result %0d/%h/%h/%h", $time,
                             i_status, i_src_mac, i_dst_mac, i_src_ip);
                    fails++;
                end else begin
                    want = pending_replies.pop_front();
                    if (got != want) begin
                        $display("%0t: result expected %0d/%h/%h/%h got %0d/%h/%h/%h",
                                 $time, want.status, want.src_mac, want.dst_mac,
                                 want.src_ip, i_status, i_src_mac, i_dst_mac, i_src_ip);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = '0;
                case (t_op'(i_op))
                    OP_ADD: begin
                        if (route_count >= ENTRIES) begin
                            want.status = ST_FULL;
                        end else begin
                            rt_dest[route_count]  = i_dest_addr;
                            rt_mask[route_count]  = i_dest_mask;
                            rt_flags[route_count] = i_present_flags;
                            rt_dist[route_count]  = i_route_distance;
                            rt_cost[route_count]  = i_route_cost;
                            rt_imac[route_count]  = i_iface_mac;
                            rt_gmac[route_count]  = i_gateway_mac;
                            rt_iip[route_count]   = i_iface_ip;
                            route_count++;
                        end
                    end
                    OP_CLEAR: begin
                        route_count = 0;
                    end
                    OP_LOOKUP: begin
                        want = resolve_lookup(i_dest_addr);
                    end
                    default: begin
                    end
                endcase
                pending_replies.insert(pending_replies.size(), want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_replies.size();
    end

endmodule

>>> tb/ipv4_route_lookup_table_test.sv
module ipv4_route_lookup_table_test;
    import rlt_pkg::*;

    localparam int TIMEOUT_CYCLES = 3_000_000;
    localparam int PHASE_ITEMS    = 480;

    // present_flags patterns
    localparam logic [4:0] ALL_FLAGS = 5'b11111;
    localparam logic [4:0] NO_MASK   = 5'b11101;
    localparam logic [4:0] NO_DEST   = 5'b11110;
    localparam logic [4:0] NO_GMAC   = 5'b10111;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [31:0] i_dest_addr;
    logic [31:0] i_dest_mask;
    logic [4:0]  i_present_flags;
    logic [7:0]  i_route_distance;
    logic [31:0] i_route_cost;
    logic [47:0] i_iface_mac;
    logic [47:0] i_gateway_mac;
    logic [31:0] i_iface_ip;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [47:0] o_src_mac;
    logic [47:0] o_dst_mac;
    logic [31:0] o_src_ip;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int out_stall_pct = 0;
    int items_sent = 0;

    // Routes known to be in the table, used to aim lookups
    int          n_stored = 0;
    logic [31:0] stored_dest  [ENTRIES];
    logic [31:0] stored_mask  [ENTRIES];
    logic [4:0]  stored_flags [ENTRIES];
    logic [31:0] addr_pool    [4];

    ipv4_route_lookup_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_dest_addr      (i_dest_addr),
        .i_dest_mask      (i_dest_mask),
        .i_present_flags  (i_present_flags),
        .i_route_distance (i_route_distance),
        .i_route_cost     (i_route_cost),
        .i_iface_mac      (i_iface_mac),
        .i_gateway_mac    (i_gateway_mac),
        .i_iface_ip       (i_iface_ip),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_src_mac        (o_src_mac),
        .o_dst_mac        (o_dst_mac),
        .o_src_ip         (o_src_ip)
    );

    route_lookup_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_dest_addr      (i_dest_addr),
        .i_dest_mask      (i_dest_mask),
        .i_present_flags  (i_present_flags),
        .i_route_distance (i_route_distance),
        .i_route_cost     (i_route_cost),
        .i_iface_mac      (i_iface_mac),
        .i_gateway_mac    (i_gateway_mac),
        .i_iface_ip       (i_iface_ip),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_src_mac        (o_src_mac),
        .i_dst_mac        (o_dst_mac),
        .i_src_ip         (o_src_ip),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("status: fail");
        $finish;
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), $urandom};
    endfunction

    task automatic send_item(input t_op op, input logic [31:0] addr, input logic [31:0] mask,
                             input logic [4:0] flags, input logic [7:0] distance,
                             input logic [31:0] cost, input logic [47:0] imac,
                             input logic [47:0] gmac, input logic [31:0] iip);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_op             <= op;
        i_dest_addr      <= addr;
        i_dest_mask      <= mask;
        i_present_flags  <= flags;
        i_route_distance <= distance;
        i_route_cost     <= cost;
        i_iface_mac      <= imac;
        i_gateway_mac    <= gmac;
        i_iface_ip       <= iip;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Operation whose other fields are ignored: fill them with noise
    task automatic send_op(input t_op op, input logic [31:0] addr);
        send_item(op, addr, $urandom, 5'($urandom), 8'($urandom), $urandom,
                  rand_mac(), rand_mac(), $urandom);
    endtask

    task automatic add_route(input logic [31:0] dest, input logic [31:0] mask,
                             input logic [4:0] flags, input logic [7:0] distance,
                             input logic [31:0] cost, input logic [47:0] imac,
                             input logic [47:0] gmac, input logic [31:0] iip);
        if (n_stored < ENTRIES) begin
            stored_dest[n_stored]  = dest;
            stored_mask[n_stored]  = mask;
            stored_flags[n_stored] = flags;
            n_stored++;
        end
        send_item(OP_ADD, dest, mask, flags, distance, cost, imac, gmac, iip);
    endtask

    task automatic clear_table();
        n_stored = 0;
        send_op(OP_CLEAR, $urandom);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic add_random_route();
        int          plen;
        int          r;
        logic [31:0] mask;
        logic [31:0] dest;
        logic [4:0]  flags;
        logic [7:0]  distance;
        logic [31:0] cost;
        plen = $urandom_range(32);
        if ($urandom_range(99) < 85) begin
            mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
        end else begin
            mask = $urandom;
        end
        // share a few base addresses so prefixes overlap and compete
        dest     = ($urandom_range(99) < 85) ? (addr_pool[$urandom_range(3)] & mask) : $urandom;
        r        = $urandom_range(99);
        flags    = (r < 55) ? ALL_FLAGS : (r < 75) ? NO_MASK : 5'($urandom);
        r        = $urandom_range(99);
        distance = (r < 30) ? 8'($urandom_range(2)) : (r < 40) ? 8'hFF : 8'($urandom);
        r        = $urandom_range(99);
        cost     = (r < 30) ? $urandom_range(2) : (r < 40) ? 32'hFFFF_FFFF : $urandom;
        add_route(dest, mask, flags, distance, cost, rand_mac(), rand_mac(), $urandom);
    endtask

    task automatic lookup_random();
        int          r;
        int          k;
        logic [31:0] addr;
        r = $urandom_range(99);
        if (n_stored > 0 && r < 75) begin
            // aim at a stored route, random bits outside its mask
            k = $urandom_range(n_stored - 1);
            if (stored_flags[k][FLAG_MASK]) begin
                addr = (stored_dest[k] & stored_mask[k]) | ($urandom & ~stored_mask[k]);
            end else begin
                addr = stored_dest[k];
            end
        end else if (r < 90) begin
            addr = addr_pool[$urandom_range(3)] ^ ($urandom >> $urandom_range(31, 8));
        end else begin
            addr = $urandom;
        end
        send_op(OP_LOOKUP, addr);
    endtask

    task automatic run_route_set();
        int n_add;
        int n_look;
        if ($urandom_range(99) < 70) clear_table();
        if ($urandom_range(99) < 8) begin
            n_add = $urandom_range(70, 60);
        end else begin
            n_add = $urandom_range(12, 0);
        end
        repeat (n_add) add_random_route();
        n_look = $urandom_range(10, 2);
        repeat (n_look) begin
            if ($urandom_range(99) < 4) begin
                send_op(OP_NOP, $urandom);
            end else begin
                lookup_random();
            end
        end
    endtask

    initial begin : stimulus
        int phase_end;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_op             <= OP_NOP;
        i_dest_addr      <= '0;
        i_dest_mask      <= '0;
        i_present_flags  <= '0;
        i_route_distance <= '0;
        i_route_cost     <= '0;
        i_iface_mac      <= '0;
        i_gateway_mac    <= '0;
        i_iface_ip       <= '0;
        foreach (addr_pool[j]) addr_pool[j] = $urandom;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, then an ignored op with every bit set
        send_op(OP_LOOKUP, 32'h0);
        send_item(OP_NOP, '1, '1, '1, '1, '1, '1, '1, '1);
        add_route(32'h0A00_0000, 32'hFF00_0000, ALL_FLAGS, 8'h00, 32'h0, '0, '0, '0);
        add_route(32'h0A01_0000, 32'hFFFF_0000, ALL_FLAGS, 8'hFF, 32'hFFFF_FFFF,
                  '1, '1, '1);
        add_route(32'h0A01_0000, 32'hFFFF_0000, ALL_FLAGS, 8'd10, 32'd5,
                  48'h0000_0000_00A1, 48'h0000_0000_00A2, 32'h0000_00A3);
        // same prefix, distance and cost: the earlier entry must win
        add_route(32'h0A01_0000, 32'hFFFF_0000, ALL_FLAGS, 8'd10, 32'd5,
                  48'h0000_0000_00B1, 48'h0000_0000_00B2, 32'h0000_00B3);
        send_op(OP_LOOKUP, 32'h0A01_0909);
        add_route(32'h0A01_0000, 32'hFFFF_0000, ALL_FLAGS, 8'd10, 32'd4,
                  48'h0000_0000_00C1, 48'h0000_0000_00C2, 32'h0000_00C3);
        send_op(OP_LOOKUP, 32'h0A01_0909);
        // route without mask counts as a full-length prefix
        add_route(32'h0A01_0203, 32'h0, NO_MASK, 8'd200, 32'hFFFF_FFFF,
                  rand_mac(), rand_mac(), $urandom);
        add_route(32'h0A01_0204, 32'hFFFF_FFFF, NO_DEST, 8'd0, 32'd0,
                  rand_mac(), rand_mac(), $urandom);
        add_route(32'h0A02_0000, 32'hFFFF_0000, NO_GMAC, 8'd0, 32'd0,
                  rand_mac(), rand_mac(), $urandom);
        add_route(32'h0, 32'h0, ALL_FLAGS, 8'd1, 32'd1, rand_mac(), rand_mac(), $urandom);
        // destination outside its own mask can never match
        add_route(32'hF0F0_F0F0, 32'h0F0F_0F0F, ALL_FLAGS, 8'd0, 32'd0,
                  rand_mac(), rand_mac(), $urandom);
        send_op(OP_LOOKUP, 32'h0A01_0203);
        send_op(OP_LOOKUP, 32'h0A01_0204);
        send_op(OP_LOOKUP, 32'h0A09_0909);
        send_op(OP_LOOKUP, 32'h0A02_0505);
        send_op(OP_LOOKUP, 32'hC0A8_0001);
        send_op(OP_LOOKUP, 32'hFFFF_FFFF);
        send_op(OP_LOOKUP, 32'h0);
        clear_table();
        send_op(OP_LOOKUP, 32'h0A01_0203);
        add_route(32'h0A01_0203, 32'h0, NO_MASK, 8'd3, 32'd3, rand_mac(), rand_mac(), $urandom);
        send_op(OP_LOOKUP, 32'h0A01_0203);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;
                    out_stall_pct <= 0;
                end
                1: begin
                    idle_pct = 60;
                    out_stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    out_stall_pct <= 60;
                end
                default: begin
                    idle_pct = 18;
                    out_stall_pct <= 18;
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) run_route_set();
            // hold the sender until every result is back
            wait_drained();
        end

        repeat (ENTRIES + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/rlt_pkg.sv
src/rlt_cell.sv
src/ipv4_route_lookup_table.sv
tb/route_lookup_checker.sv
tb/ipv4_route_lookup_table_test.sv
